// ----- src/nstt_pkg.sv -----
package nstt_pkg;

    localparam int DEFAULT_TABLE_SLOTS = 16;
    localparam logic [26:0] TIMEOUT_RESET = 27'd15000;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_BADCHECK = 3'd2,
        KIND_REPORT   = 3'd3,
        KIND_EVICT    = 3'd4,
        KIND_SUMMARY  = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_PLAIN,
        ST_SWEEP,
        ST_SWEEP_OUT,
        ST_SUMMARY,
        ST_WAIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic   load;
        logic   scan_clear;
        logic   scan_step;
        logic   update;
        logic   sweep_emit;
        logic   plain_emit;
        kind_t  plain_kind;
        logic   count_reject;
        logic   count_accept;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_sweep;
        logic check_ok;
        logic scan_done;
        logic found;
        logic free_found;
        logic cur_active;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- src/nstt_ctrl.sv -----
module nstt_ctrl
    import nstt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  dp_status_t status,
    output logic       in_ready,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (status.is_sweep)
                    state_next = ST_SWEEP;
                else if (!status.check_ok)
                    state_next = ST_PLAIN;
                else
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (status.scan_done)
                    state_next = (status.found || status.free_found) ? ST_UPDATE : ST_PLAIN;
            end
            ST_UPDATE:
            begin
                if (!status.out_busy)
                    state_next = ST_IDLE;
            end
            ST_PLAIN:
            begin
                if (!status.out_busy)
                    state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (status.scan_done)
                    state_next = ST_SUMMARY;
                else if (status.cur_active)
                    state_next = ST_SWEEP_OUT;
            end
            ST_SWEEP_OUT:
            begin
                if (!status.out_busy)
                    state_next = ST_SWEEP;
            end
            ST_SUMMARY:
            begin
                if (!status.out_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        cmd.plain_kind = KIND_SUMMARY;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            ST_WAIT:
            begin
                cmd.scan_clear = 1'b1;
                cmd.count_reject = !status.is_sweep && !status.check_ok;
                cmd.count_accept = !status.is_sweep && status.check_ok;
            end
            ST_LOOKUP:
            begin
                cmd.scan_step = !status.scan_done;
            end
            ST_UPDATE:
            begin
                cmd.update = !status.out_busy;
            end
            ST_PLAIN:
            begin
                cmd.plain_emit = !status.out_busy;
                cmd.plain_kind = status.check_ok ? KIND_FULL : KIND_BADCHECK;
            end
            ST_SWEEP:
            begin
                cmd.scan_step = !status.scan_done && !status.cur_active;
            end
            ST_SWEEP_OUT:
            begin
                cmd.sweep_emit = !status.out_busy;
                cmd.scan_step = !status.out_busy;
            end
            ST_SUMMARY:
            begin
                cmd.plain_emit = !status.out_busy;
                cmd.plain_kind = KIND_SUMMARY;
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.update && cmd.sweep_emit) && !(cmd.update && cmd.plain_emit))
        else $error("conflicting emit commands");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("ready after accept");
    a_load_fire: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> in_fire)
        else $error("load without transfer");
`endif

endmodule

// ----- src/nstt_dp.sv -----
module nstt_dp
    import nstt_pkg::*;
#(
    parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [26:0]  cfg_data,
    input  logic [113:0] in_data,
    input  dp_cmd_t      cmd,
    output dp_status_t   status,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [247:0] out_data,
    output logic         out_last
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    // Slot table
    logic [TABLE_SLOTS-1:0] act_reg;
    logic [7:0]  node_reg  [TABLE_SLOTS];
    logic [31:0] seq_reg   [TABLE_SLOTS];
    logic [31:0] rx_reg    [TABLE_SLOTS];
    logic [7:0]  raw_reg   [TABLE_SLOTS];
    logic [15:0] filt_reg  [TABLE_SLOTS];
    logic [31:0] pkt_reg   [TABLE_SLOTS];
    logic [31:0] dup_reg   [TABLE_SLOTS];
    logic [31:0] lost_reg  [TABLE_SLOTS];
    logic [15:0] flag_reg  [TABLE_SLOTS];

    logic [26:0]  timeout_reg;
    logic [31:0]  acc_reg, rej_reg;
    logic [113:0] item_reg;
    logic [CW-1:0] scan_reg;
    logic         found_reg, free_reg;
    logic [IW-1:0] hit_reg, freeidx_reg;
    logic         ov_reg;
    logic [247:0] od_reg;
    logic         ol_reg;

    logic        i_cmd;
    logic [7:0]  i_id;
    logic [31:0] i_seq, i_now;
    logic [7:0]  i_raw;
    logic [15:0] i_filt, i_flags;
    logic        i_ok;
    assign i_cmd   = item_reg[0];
    assign i_id    = item_reg[8:1];
    assign i_seq   = item_reg[40:9];
    assign i_raw   = item_reg[48:41];
    assign i_filt  = item_reg[64:49];
    assign i_flags = item_reg[80:65];
    assign i_ok    = item_reg[81];
    assign i_now   = item_reg[113:82];

    logic [IW-1:0] cur;
    logic [IW-1:0] tgt;
    logic          scan_done;
    assign cur = scan_reg[IW-1:0];
    assign scan_done = (scan_reg == CW'(TABLE_SLOTS));
    assign tgt = found_reg ? hit_reg : freeidx_reg;

    // Update arithmetic for the target slot
    logic        t_new;
    logic [31:0] t_seq, t_pkt, t_dup, t_lost, t_next, n_pkt, n_dup, n_lost;
    logic [31:0] age;
    always_comb
    begin
        t_new  = !found_reg;
        t_seq  = t_new ? 32'd0 : seq_reg[tgt];
        t_pkt  = t_new ? 32'd0 : pkt_reg[tgt];
        t_dup  = t_new ? 32'd0 : dup_reg[tgt];
        t_lost = t_new ? 32'd0 : lost_reg[tgt];
        t_next = t_seq + 32'd1;
        n_dup  = t_dup;
        n_lost = t_lost;
        if (t_pkt != 32'd0)
        begin
            if (i_seq == t_seq)
                n_dup = t_dup + 32'd1;
            else if (i_seq > t_next)
                n_lost = t_lost + (i_seq - t_next);
        end
        n_pkt = t_pkt + 32'd1;
        age   = i_now - rx_reg[cur];
    end

    logic evict;
    assign evict = age > {5'd0, timeout_reg};

    assign status.is_sweep   = i_cmd;
    assign status.check_ok   = i_ok;
    assign status.scan_done  = scan_done;
    assign status.found      = found_reg;
    assign status.free_found = free_reg;
    assign status.cur_active = !scan_done && act_reg[cur];
    assign status.out_busy   = ov_reg && !out_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            acc_reg     <= '0;
            rej_reg     <= '0;
            act_reg     <= '0;
            scan_reg    <= '0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                timeout_reg <= cfg_data;
            if (cmd.count_accept)
                acc_reg <= acc_reg + 32'd1;
            if (cmd.count_reject)
                rej_reg <= rej_reg + 32'd1;
            if (cmd.scan_clear)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (!i_cmd)
                begin
                    if (!found_reg && act_reg[cur] && node_reg[cur] == i_id)
                        found_reg <= 1'b1;
                    if (!free_reg && !act_reg[cur])
                        free_reg <= 1'b1;
                end
                scan_reg <= scan_reg + CW'(1);
            end
            if (cmd.update)
                act_reg[tgt] <= 1'b1;
            if (cmd.sweep_emit && evict)
                act_reg[cur] <= 1'b0;
            if (cmd.update || cmd.sweep_emit || cmd.plain_emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_data;
        if (cmd.scan_step && !i_cmd)
        begin
            if (!found_reg && act_reg[cur] && node_reg[cur] == i_id)
                hit_reg <= cur;
            if (!free_reg && !act_reg[cur])
                freeidx_reg <= cur;
        end
        if (cmd.update)
        begin
            node_reg[tgt] <= i_id;
            seq_reg[tgt]  <= i_seq;
            rx_reg[tgt]   <= i_now;
            raw_reg[tgt]  <= i_raw;
            filt_reg[tgt] <= i_filt;
            flag_reg[tgt] <= i_flags;
            pkt_reg[tgt]  <= n_pkt;
            dup_reg[tgt]  <= n_dup;
            lost_reg[tgt] <= n_lost;
            od_reg <= {5'd0, rej_reg, 32'd0, i_flags, n_lost, n_dup, n_pkt, i_filt, i_raw,
                       i_seq, i_id, KIND_ACCEPTED};
            ol_reg <= 1'b1;
        end
        else if (cmd.sweep_emit)
        begin
            od_reg <= {5'd0, rej_reg, age, flag_reg[cur], lost_reg[cur], dup_reg[cur],
                       pkt_reg[cur], filt_reg[cur], raw_reg[cur], seq_reg[cur],
                       node_reg[cur], evict ? KIND_EVICT : KIND_REPORT};
            ol_reg <= 1'b0;
        end
        else if (cmd.plain_emit)
        begin
            od_reg <= {5'd0, rej_reg, 32'd0, 16'd0, 32'd0, 32'd0,
                       (cmd.plain_kind == KIND_SUMMARY) ? acc_reg : 32'd0,
                       16'd0, 8'd0, 32'd0,
                       (cmd.plain_kind == KIND_SUMMARY) ? 8'd0 : i_id, cmd.plain_kind};
            ol_reg <= 1'b1;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_last  = ol_reg;

`ifndef NO_ASSERTIONS
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= CW'(TABLE_SLOTS))
        else $error("scan index out of range");
    a_update_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (found_reg || free_reg))
        else $error("update without slot");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update || cmd.sweep_emit || cmd.plain_emit) |-> !(ov_reg && !out_ready))
        else $error("result overwritten");
`endif

endmodule

// ----- src/node_sequence_tracking_table.sv -----
// Channel      | Dir | Payload
// s_axis       | in  | tdata: command, node_id, seq_number, raw_rssi, filtered_rssi_x10,
//              |     |        flag_word, check_ok, now_ms (low bit up)
// m_axis       | out | tdata: kind .. check_fail_total; tlast: last
// cfg          | in  | cfg_we / cfg_data: node_timeout_ms
//
// For a good packet the lookup walks the slot table one slot per cycle.
// A packet with a bad check skips the lookup.
// A sweep walks the whole table and stops on each active slot to emit its report.
// Reset clears the table valid bits and totals and loads the default timeout.
// A stalled result holds the sequencer; input is taken only between items.
module node_sequence_tracking_table
    import nstt_pkg::*;
#(
    parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [26:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command, node_id, seq_number, raw_rssi, filtered_rssi_x10, flag_word,
    // check_ok, now_ms, zero fill
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind, entry_id, stored sequence, stored raw rssi, stored filtered rssi,
    // packet_total, duplicate_total, lost_total, stored_flags, age_ms,
    // check_fail_total, zero fill
    output logic [247:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_fire;
    logic [113:0] in_data;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    // Drop the zero fill
    assign in_data = s_axis_tdata[113:0];

    nstt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    nstt_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
